FILE: rtl/byte_stuffing_framer_top_defines.svh
// ----------------------------------------------------------------------------
// byte stuffing framer assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFING_FRAMER_TOP_DEFINES_SVH
`define BYTE_STUFFING_FRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define BSF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsf assertion failed (same cycle)");

// next-cycle implication
`define BSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsf assertion failed (next cycle)");

`endif

FILE: rtl/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// types and constants shared by the byte stuffing framer modules
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FLAG   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE = 1'b1;

  // kind of each line byte
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_FLAG    = 2'd1,
    KIND_ESCAPE  = 2'd2
  } kind_e;

  // classified item handed from front to back
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] flag_byte;
    logic [ByteW-1:0] esc_byte;
    logic             open;
    logic             esc;
    logic             close;
  } cmd_t;

endpackage

FILE: rtl/bsf_front.sv
// ----------------------------------------------------------------------------
// bsf_front
// accepts payload bytes, tracks the open frame and classifies each byte
// ----------------------------------------------------------------------------
module bsf_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [bsf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bsf_pkg::ByteW-1:0]         cfg_wdata_i,
  // input stream
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [bsf_pkg::ByteW-1:0]         s_tdata_i,
  input  logic                              s_tlast_i,
  // queue write side
  output logic                              push_o,
  output bsf_pkg::cmd_t                     cmd_o,
  input  logic                              q_ready_i
);

  logic [bsf_pkg::ByteW-1:0] flag_q, flag_d;
  logic [bsf_pkg::ByteW-1:0] esc_q, esc_d;
  logic                      open_q, open_d;

  // register writes
  always_comb begin
    flag_d = flag_q;
    esc_d  = esc_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bsf_pkg::CFG_FLAG:   flag_d = cfg_wdata_i;
        bsf_pkg::CFG_ESCAPE: esc_d  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // classify the incoming byte
  assign s_tready_o = q_ready_i;
  assign push_o     = s_tvalid_i && q_ready_i;

  always_comb begin
    cmd_o.data      = s_tdata_i;
    cmd_o.flag_byte = flag_q;
    cmd_o.esc_byte  = esc_q;
    cmd_o.open      = !open_q;
    cmd_o.esc       = (s_tdata_i == flag_q) || (s_tdata_i == esc_q);
    cmd_o.close     = s_tlast_i;
  end

  // frame open tracking
  assign open_d = push_o ? !s_tlast_i : open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 8'h0F;
      esc_q  <= 8'h06;
      open_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
      esc_q  <= esc_d;
      open_q <= open_d;
    end
  end

endmodule

FILE: rtl/bsf_queue.sv
// ----------------------------------------------------------------------------
// bsf_queue
// small command queue decoupling the front from the back
// ----------------------------------------------------------------------------
`include "byte_stuffing_framer_top_defines.svh"

module bsf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsf_pkg::cmd_t cmd_i,
  output logic          ready_o,
  input  logic          pop_i,
  output bsf_pkg::cmd_t head_o,
  output logic          valid_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  bsf_pkg::cmd_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign ready_o = (count_q != CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill tracking
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  `BSF_ASSERT_SAME(a_no_pop_when_empty, pop_i, count_q != '0)

endmodule

FILE: rtl/bsf_back.sv
// ----------------------------------------------------------------------------
// bsf_back
// expands each command into payload plus any opening flag, escape, closing flag
// ----------------------------------------------------------------------------
`include "byte_stuffing_framer_top_defines.svh"

module bsf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // queue read side
  input  logic                      q_valid_i,
  input  bsf_pkg::cmd_t             head_i,
  output logic                      pop_o,
  // output stream
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output logic [bsf_pkg::ByteW-1:0] m_tdata_o,
  output logic [1:0]                m_tuser_o,
  output logic                      m_tlast_o
);

  typedef enum logic [3:0] {
    PH_OPEN  = 4'b0001,
    PH_ESC   = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_CLOSE = 4'b1000
  } phase_e;

  bsf_pkg::cmd_t             cur_q, cur_d;
  logic                      busy_q, busy_d;
  phase_e                    phase_q, phase_d, phase_nxt, phase_first;
  logic                      out_valid_q, out_valid_d;
  logic [bsf_pkg::ByteW-1:0] out_data_q, out_data_d;
  bsf_pkg::kind_e            out_kind_q, out_kind_d;
  logic                      out_last_q, out_last_d;
  logic                      out_free, load, fin;
  logic [bsf_pkg::ByteW-1:0] cur_byte;
  bsf_pkg::kind_e            cur_kind;

  // byte of the current phase and the phase after it
  always_comb begin
    cur_byte  = cur_q.data;
    cur_kind  = bsf_pkg::KIND_PAYLOAD;
    fin       = 1'b1;
    phase_nxt = PH_DATA;
    unique case (phase_q)
      PH_OPEN: begin
        cur_byte  = cur_q.flag_byte;
        cur_kind  = bsf_pkg::KIND_FLAG;
        fin       = 1'b0;
        phase_nxt = cur_q.esc ? PH_ESC : PH_DATA;
      end
      PH_ESC: begin
        cur_byte  = cur_q.esc_byte;
        cur_kind  = bsf_pkg::KIND_ESCAPE;
        fin       = 1'b0;
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        cur_byte  = cur_q.data;
        cur_kind  = bsf_pkg::KIND_PAYLOAD;
        fin       = !cur_q.close;
        phase_nxt = PH_CLOSE;
      end
      PH_CLOSE: begin
        cur_byte  = cur_q.flag_byte;
        cur_kind  = bsf_pkg::KIND_FLAG;
        fin       = 1'b1;
        phase_nxt = PH_CLOSE;
      end
      default: ;
    endcase
  end

  // first phase of the waiting command
  always_comb begin
    if (head_i.open) begin
      phase_first = PH_OPEN;
    end else if (head_i.esc) begin
      phase_first = PH_ESC;
    end else begin
      phase_first = PH_DATA;
    end
  end

  // sequencing: take the next command as the last byte of this one leaves
  assign out_free = !out_valid_q || m_tready_i;
  assign load     = busy_q && out_free;
  assign pop_o    = q_valid_i && (!busy_q || (load && fin));

  always_comb begin
    cur_d   = cur_q;
    busy_d  = busy_q;
    phase_d = phase_q;
    if (pop_o) begin
      cur_d   = head_i;
      busy_d  = 1'b1;
      phase_d = phase_first;
    end else if (load && fin) begin
      busy_d  = 1'b0;
    end else if (load) begin
      phase_d = phase_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_data_d  = cur_byte;
      out_kind_d  = cur_kind;
      out_last_d  = fin;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_DATA;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

  `BSF_ASSERT_NEXT(a_esc_then_payload,
    m_tvalid_o && m_tready_i && (out_kind_q == bsf_pkg::KIND_ESCAPE),
    m_tvalid_o && (out_kind_q == bsf_pkg::KIND_PAYLOAD))
  `BSF_ASSERT_SAME(a_esc_not_last,
    m_tvalid_o && (out_kind_q == bsf_pkg::KIND_ESCAPE), !m_tlast_o)
  `BSF_ASSERT_SAME(a_close_phase_needs_close, busy_q && (phase_q == PH_CLOSE), cur_q.close)

endmodule

FILE: rtl/byte_stuffing_framer_top.sv
// ----------------------------------------------------------------------------
// byte_stuffing_framer_top
// flag-delimited byte stuffing framer, transmit side
//
// channel   direction  tdata             tuser          tlast
// s_axis    in         payload_byte[7:0] -              frame_end
// m_axis    out        line_byte[7:0]    byte_kind[1:0] run_last
// cfg       in         index 0 flag_byte, index 1 escape_byte, write only
//
// one payload byte per cycle while the output is ready and no flag or escape is inserted;
// each opening flag, escape or closing flag adds one line byte, from the back's single output register
// first byte passes the queue, the back's command register and its output register
// reset clears frame state and sets flag 0x0F, escape 0x06
// a stalled output fills the queue, then s_axis_tready drops
// ----------------------------------------------------------------------------
module byte_stuffing_framer_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              cfg_we_i,
  input  logic [bsf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bsf_pkg::ByteW-1:0]         cfg_wdata_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] payload_byte
  input  logic                              s_axis_tlast,   // frame_end
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [7:0] line_byte
  output logic [1:0]                        m_axis_tuser,   // [1:0] byte_kind
  output logic                              m_axis_tlast    // run_last
);

  logic          push, q_ready, pop, q_valid;
  bsf_pkg::cmd_t cmd, head;

  // classification front
  bsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .push_o      (push),
    .cmd_o       (cmd),
    .q_ready_i   (q_ready)
  );

  // command queue
  bsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (q_valid)
  );

  // byte sequencer back
  bsf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
